### sv/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### sv/stus_pkg.sv
// Shared types and constants of the sparse triplet store.
package stus_pkg;

    localparam int CAPACITY    = 256;
    localparam int COORD_BITS  = 16;
    localparam int ADDR_BITS   = $clog2(CAPACITY);
    localparam int CNT_BITS    = $clog2(CAPACITY + 1);
    localparam int PORT_COORD  = 16;
    localparam int VALUE_BITS  = 64;
    localparam int ELEM_BITS   = 9;
    localparam int INDEX_BITS  = 8;
    localparam int ENTRY_BITS  = 9;
    localparam int WORD_BITS   = 2 * COORD_BITS + VALUE_BITS;

    typedef enum logic [2:0] {
        CMD_CLEAR       = 3'd0,
        CMD_APPEND      = 3'd1,
        CMD_UPSERT      = 3'd2,
        CMD_APPEND_DIAG = 3'd3,
        CMD_UPSERT_DIAG = 3'd4,
        CMD_READ        = 3'd5
    } stus_cmd_code_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } stus_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ELEM,
        ST_SCAN,
        ST_RDADDR,
        ST_READ,
        ST_FINISH
    } stus_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic write_hit;
        logic append;
        logic advance;
        logic read_issue;
        logic read_capture;
        logic read_miss;
        logic out_load;
    } stus_ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic elem_zero;
        logic upsert_mode;
        logic match;
        logic scan_done;
        logic index_ok;
    } stus_stat_t;

endpackage

### sv/stus_datapath.sv
// Datapath of the sparse triplet store: entry memory, scan pipeline and result registers.
module stus_datapath
    import stus_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  stus_ctrl_t              ctrl,
    output stus_stat_t              stat,
    input  logic [2:0]              cmd,
    input  logic [PORT_COORD-1:0]   row,
    input  logic [PORT_COORD-1:0]   column,
    input  logic [VALUE_BITS-1:0]   value,
    input  logic [ELEM_BITS-1:0]    count,
    input  logic [INDEX_BITS-1:0]   index,
    output logic [1:0]              status,
    output logic [ENTRY_BITS-1:0]   entry_count,
    output logic                    replaced,
    output logic [PORT_COORD-1:0]   read_row,
    output logic [PORT_COORD-1:0]   read_column,
    output logic [VALUE_BITS-1:0]   read_value
);

    logic [WORD_BITS-1:0]  mem [CAPACITY];

    logic [COORD_BITS-1:0] cur_row_reg, cur_row_next;
    logic [COORD_BITS-1:0] cur_col_reg, cur_col_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic [ELEM_BITS-1:0]  elem_left_reg, elem_left_next;
    logic                  upsert_reg, upsert_next;
    logic [INDEX_BITS-1:0] index_reg, index_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [CNT_BITS-1:0]   scan_ptr_reg, scan_ptr_next;
    logic                  rd_pend_reg, rd_pend_next;
    logic [ADDR_BITS-1:0]  rd_addr_reg, rd_addr_next;
    logic [WORD_BITS-1:0]  rd_word_reg;
    logic                  full_reg, full_next;
    logic                  hit_reg, hit_next;
    logic                  miss_reg, miss_next;
    logic                  read_ok_reg, read_ok_next;

    logic [1:0]            status_reg, status_next;
    logic [ENTRY_BITS-1:0] entry_count_reg, entry_count_next;
    logic                  replaced_reg, replaced_next;
    logic [PORT_COORD-1:0] read_row_reg, read_row_next;
    logic [PORT_COORD-1:0] read_col_reg, read_col_next;
    logic [VALUE_BITS-1:0] read_value_reg, read_value_next;

    logic                  table_full;
    logic                  scan_more;
    logic                  scan_issue;
    logic                  mem_we;
    logic [ADDR_BITS-1:0]  mem_waddr;
    logic                  mem_re;
    logic [ADDR_BITS-1:0]  mem_raddr;
    logic [COORD_BITS-1:0] rd_row;
    logic [COORD_BITS-1:0] rd_col;
    logic [VALUE_BITS-1:0] rd_value;

    assign rd_row   = rd_word_reg[WORD_BITS-1 -: COORD_BITS];
    assign rd_col   = rd_word_reg[VALUE_BITS +: COORD_BITS];
    assign rd_value = rd_word_reg[VALUE_BITS-1:0];

    assign table_full = (count_reg == CNT_BITS'(CAPACITY));
    assign scan_more  = (scan_ptr_reg < count_reg);
    assign scan_issue = ctrl.scan_step && scan_more;

    assign mem_we    = ctrl.write_hit || (ctrl.append && !table_full);
    assign mem_waddr = ctrl.write_hit ? rd_addr_reg : count_reg[ADDR_BITS-1:0];
    assign mem_re    = scan_issue || ctrl.read_issue;
    assign mem_raddr = ctrl.read_issue ? ADDR_BITS'(index_reg)
                                       : scan_ptr_reg[ADDR_BITS-1:0];

    assign stat.elem_zero   = (elem_left_reg == '0);
    assign stat.upsert_mode = upsert_reg;
    assign stat.match       = rd_pend_reg && (rd_row == cur_row_reg)
                              && (rd_col == cur_col_reg);
    assign stat.scan_done   = !rd_pend_reg && !scan_more;
    assign stat.index_ok    = (CNT_BITS'(index_reg) < count_reg);

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= {cur_row_reg, cur_col_reg, value_reg};
        end
        if (mem_re)
        begin
            rd_word_reg <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        cur_row_next     = cur_row_reg;
        cur_col_next     = cur_col_reg;
        value_next       = value_reg;
        elem_left_next   = elem_left_reg;
        upsert_next      = upsert_reg;
        index_next       = index_reg;
        count_next       = count_reg;
        scan_ptr_next    = scan_ptr_reg;
        rd_pend_next     = rd_pend_reg;
        rd_addr_next     = rd_addr_reg;
        full_next        = full_reg;
        hit_next         = hit_reg;
        miss_next        = miss_reg;
        read_ok_next     = read_ok_reg;
        status_next      = status_reg;
        entry_count_next = entry_count_reg;
        replaced_next    = replaced_reg;
        read_row_next    = read_row_reg;
        read_col_next    = read_col_reg;
        read_value_next  = read_value_reg;

        if (ctrl.load)
        begin
            cur_row_next = COORD_BITS'(row);
            cur_col_next = COORD_BITS'(column);
            value_next   = value;
            index_next   = index;
            full_next    = 1'b0;
            hit_next     = 1'b0;
            miss_next    = 1'b0;
            read_ok_next = 1'b0;
            unique case (stus_cmd_code_t'(cmd))
                CMD_CLEAR:
                begin
                    count_next     = '0;
                    elem_left_next = '0;
                    upsert_next    = 1'b0;
                end
                CMD_APPEND:
                begin
                    elem_left_next = ELEM_BITS'(1);
                    upsert_next    = 1'b0;
                end
                CMD_UPSERT:
                begin
                    elem_left_next = ELEM_BITS'(1);
                    upsert_next    = 1'b1;
                end
                CMD_APPEND_DIAG:
                begin
                    elem_left_next = count;
                    upsert_next    = 1'b0;
                end
                CMD_UPSERT_DIAG:
                begin
                    elem_left_next = count;
                    upsert_next    = 1'b1;
                end
                default:
                begin
                    elem_left_next = '0;
                    upsert_next    = 1'b0;
                end
            endcase
        end

        if (ctrl.scan_start)
        begin
            scan_ptr_next = '0;
            rd_pend_next  = 1'b0;
        end

        if (ctrl.scan_step)
        begin
            rd_pend_next = scan_more;
            if (scan_more)
            begin
                rd_addr_next  = scan_ptr_reg[ADDR_BITS-1:0];
                scan_ptr_next = scan_ptr_reg + CNT_BITS'(1);
            end
        end

        if (ctrl.write_hit)
        begin
            hit_next = 1'b1;
        end

        if (ctrl.append)
        begin
            if (table_full)
            begin
                full_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_BITS'(1);
            end
        end

        if (ctrl.advance)
        begin
            elem_left_next = elem_left_reg - ELEM_BITS'(1);
            cur_row_next   = cur_row_reg + COORD_BITS'(1);
            cur_col_next   = cur_col_reg + COORD_BITS'(1);
        end

        if (ctrl.read_miss)
        begin
            miss_next = 1'b1;
        end

        if (ctrl.read_capture)
        begin
            read_ok_next = 1'b1;
        end

        if (ctrl.out_load)
        begin
            if (full_reg)
            begin
                status_next = STATUS_FULL;
            end
            else if (miss_reg)
            begin
                status_next = STATUS_RANGE;
            end
            else
            begin
                status_next = STATUS_OK;
            end
            entry_count_next = ENTRY_BITS'(count_reg);
            replaced_next    = hit_reg;
            read_row_next    = read_ok_reg ? PORT_COORD'(rd_row) : '0;
            read_col_next    = read_ok_reg ? PORT_COORD'(rd_col) : '0;
            read_value_next  = read_ok_reg ? rd_value : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            rd_pend_reg <= 1'b0;
            full_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            miss_reg    <= 1'b0;
            read_ok_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            rd_pend_reg <= rd_pend_next;
            full_reg    <= full_next;
            hit_reg     <= hit_next;
            miss_reg    <= miss_next;
            read_ok_reg <= read_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_row_reg     <= cur_row_next;
        cur_col_reg     <= cur_col_next;
        value_reg       <= value_next;
        elem_left_reg   <= elem_left_next;
        upsert_reg      <= upsert_next;
        index_reg       <= index_next;
        scan_ptr_reg    <= scan_ptr_next;
        rd_addr_reg     <= rd_addr_next;
        status_reg      <= status_next;
        entry_count_reg <= entry_count_next;
        replaced_reg    <= replaced_next;
        read_row_reg    <= read_row_next;
        read_col_reg    <= read_col_next;
        read_value_reg  <= read_value_next;
    end

    assign status      = status_reg;
    assign entry_count = entry_count_reg;
    assign replaced    = replaced_reg;
    assign read_row    = read_row_reg;
    assign read_column = read_col_reg;
    assign read_value  = read_value_reg;

endmodule

### sv/stus_controller.sv
// Controller state machine of the sparse triplet store.
module stus_controller
    import stus_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] cmd,
    output logic       out_valid,
    input  logic       out_stall,
    input  stus_stat_t stat,
    output stus_ctrl_t ctrl
);

    stus_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ctrl           = '0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ctrl.load = 1'b1;
                    unique case (stus_cmd_code_t'(cmd))
                        CMD_APPEND, CMD_UPSERT, CMD_APPEND_DIAG, CMD_UPSERT_DIAG:
                        begin
                            state_next = ST_ELEM;
                        end
                        CMD_READ:
                        begin
                            state_next = ST_RDADDR;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_ELEM:
            begin
                priority if (stat.elem_zero)
                begin
                    state_next = ST_FINISH;
                end
                else if (stat.upsert_mode)
                begin
                    ctrl.scan_start = 1'b1;
                    state_next      = ST_SCAN;
                end
                else
                begin
                    ctrl.append  = 1'b1;
                    ctrl.advance = 1'b1;
                end
            end
            ST_SCAN:
            begin
                priority if (stat.match)
                begin
                    ctrl.write_hit = 1'b1;
                    ctrl.advance   = 1'b1;
                    state_next     = ST_ELEM;
                end
                else if (stat.scan_done)
                begin
                    ctrl.append  = 1'b1;
                    ctrl.advance = 1'b1;
                    state_next   = ST_ELEM;
                end
                else
                begin
                    ctrl.scan_step = 1'b1;
                end
            end
            ST_RDADDR:
            begin
                if (stat.index_ok)
                begin
                    ctrl.read_issue = 1'b1;
                    state_next      = ST_READ;
                end
                else
                begin
                    ctrl.read_miss = 1'b1;
                    state_next     = ST_FINISH;
                end
            end
            ST_READ:
            begin
                ctrl.read_capture = 1'b1;
                state_next        = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    ctrl.out_load  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

### sv/sparse_triplet_upsert_store_core.sv
// Top level of the sparse triplet store: controller plus datapath.
//
// Builds a coordinate-list sparse matrix in a table of CAPACITY (row, column,
// value) entries held in a single-port-read, single-port-write memory. Takes
// one request at a time: in_stall is low only while the block is idle, and
// the finished result sits in an output register, so the next request is
// taken while that result still waits on out_stall. Clear and unused codes
// go straight to the finish state; a read checks its index, then issues the
// read and captures the word; an append writes one entry per element; an
// upsert scans the stored entries for each element, reading the memory one
// entry per cycle through its registered read port, stops at the first
// matching row and column and appends when nothing matches. The finish state
// loads the result once the output register is free, and the block then
// returns to idle. Diagonal commands run their elements one after another,
// each coordinate pair wrapping at 16 bits.
// Appends past capacity are dropped and flagged with status 1; a read index
// not below the entry count returns status 2 with zero read fields. Stored
// entries have no reset value; only entries below the count are ever read.
module sparse_triplet_upsert_store_core
    import stus_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [2:0]            cmd,
    input  logic [PORT_COORD-1:0] row,
    input  logic [PORT_COORD-1:0] column,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [ELEM_BITS-1:0]  count,
    input  logic [INDEX_BITS-1:0] index,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output logic [ENTRY_BITS-1:0] entry_count,
    output logic                  replaced,
    output logic [PORT_COORD-1:0] read_row,
    output logic [PORT_COORD-1:0] read_column,
    output logic [VALUE_BITS-1:0] read_value
);

    stus_ctrl_t ctrl;
    stus_stat_t stat;

    // Sequence each request: latch, walk elements, scan, write, hand off.
    stus_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // Hold the entry table, the scan pipeline and the result register.
    stus_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .stat        (stat),
        .cmd         (cmd),
        .row         (row),
        .column      (column),
        .value       (value),
        .count       (count),
        .index       (index),
        .status      (status),
        .entry_count (entry_count),
        .replaced    (replaced),
        .read_row    (read_row),
        .read_column (read_column),
        .read_value  (read_value)
    );

endmodule

### sv/stus_checker.sv
// Port-level assertion checker for the sparse triplet store, with its bind.
`include "assert_macros.svh"

module stus_checker
    import stus_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [1:0]            status,
    input logic [ENTRY_BITS-1:0] entry_count,
    input logic                  replaced,
    input logic [PORT_COORD-1:0] read_row,
    input logic [PORT_COORD-1:0] read_column,
    input logic [VALUE_BITS-1:0] read_value
);

    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(entry_count))
    `ASSERT_IMPL(a_count_bound, clk, rst_n, out_valid, entry_count <= ENTRY_BITS'(CAPACITY))
    `ASSERT_IMPL(a_miss_zero, clk, rst_n, out_valid && status == STATUS_RANGE, read_row == '0 && read_column == '0 && read_value == '0 && !replaced)

endmodule

bind sparse_triplet_upsert_store_core stus_checker u_stus_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .entry_count (entry_count),
    .replaced    (replaced),
    .read_row    (read_row),
    .read_column (read_column),
    .read_value  (read_value)
);

### bench/triplet_store_checker.sv
// Channel monitor and result predictor for the sparse triplet store.
module triplet_store_checker
    import stus_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [2:0]            cmd,
    input  logic [PORT_COORD-1:0] row,
    input  logic [PORT_COORD-1:0] column,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [ELEM_BITS-1:0]  count,
    input  logic [INDEX_BITS-1:0] index,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [1:0]            status,
    input  logic [ENTRY_BITS-1:0] entry_count,
    input  logic                  replaced,
    input  logic [PORT_COORD-1:0] read_row,
    input  logic [PORT_COORD-1:0] read_column,
    input  logic [VALUE_BITS-1:0] read_value,
    output int                    mismatches,
    output int                    results_owed,
    output int                    written_depth
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        stus_status_t          status;
        logic [ENTRY_BITS-1:0] entries;
        logic                  hit;
        logic [PORT_COORD-1:0] got_row;
        logic [PORT_COORD-1:0] got_column;
        logic [VALUE_BITS-1:0] got_value;
    } outcome_t;

    logic [PORT_COORD-1:0] tbl_row [CAPACITY];
    logic [PORT_COORD-1:0] tbl_column [CAPACITY];
    logic [VALUE_BITS-1:0] tbl_value [CAPACITY];
    int                    tbl_used = 0;
    int                    high_mark = 0;
    int                    miss_tally = 0;
    outcome_t              awaited_results[$];

    assign mismatches = miss_tally;

    // Append one triplet; return 0 when the table is already full.
    function automatic bit push_triplet(logic [PORT_COORD-1:0] r, logic [PORT_COORD-1:0] c,
                                        logic [VALUE_BITS-1:0] v);
        if (tbl_used >= CAPACITY)
            return 1'b0;
        tbl_row[tbl_used]    = r;
        tbl_column[tbl_used] = c;
        tbl_value[tbl_used]  = v;
        tbl_used++;
        return 1'b1;
    endfunction

    // Overwrite the first matching triplet or append. Bit 1: kept, bit 0: overwrote.
    function automatic logic [1:0] upsert_triplet(logic [PORT_COORD-1:0] r,
                                                  logic [PORT_COORD-1:0] c,
                                                  logic [VALUE_BITS-1:0] v);
        for (int k = 0; k < tbl_used; k++)
        begin
            if (tbl_row[k] == r && tbl_column[k] == c)
            begin
                tbl_value[k] = v;
                return 2'b11;
            end
        end
        return {push_triplet(r, c, v), 1'b0};
    endfunction

    // Update the shadow table for one request and build the result it owes.
    function automatic outcome_t apply_command(logic [2:0] op, logic [PORT_COORD-1:0] r,
                                               logic [PORT_COORD-1:0] c,
                                               logic [VALUE_BITS-1:0] v,
                                               logic [ELEM_BITS-1:0] n,
                                               logic [INDEX_BITS-1:0] idx);
        outcome_t              res;
        logic                  kept;
        logic [1:0]            u;
        logic [PORT_COORD-1:0] ri;
        logic [PORT_COORD-1:0] ci;
        res  = '0;
        kept = 1'b1;
        case (op)
            CMD_CLEAR:
                tbl_used = 0;
            CMD_APPEND:
                kept = push_triplet(r, c, v);
            CMD_UPSERT:
            begin
                u       = upsert_triplet(r, c, v);
                kept    = u[1];
                res.hit = u[0];
            end
            CMD_APPEND_DIAG, CMD_UPSERT_DIAG:
            begin
                for (int i = 0; i < n; i++)
                begin
                    ri = r + PORT_COORD'(i);
                    ci = c + PORT_COORD'(i);
                    if (op == CMD_APPEND_DIAG)
                    begin
                        if (!push_triplet(ri, ci, v))
                            kept = 1'b0;
                    end
                    else
                    begin
                        u = upsert_triplet(ri, ci, v);
                        if (!u[1])
                            kept = 1'b0;
                        if (u[0])
                            res.hit = 1'b1;
                    end
                end
            end
            CMD_READ:
            begin
                if (idx < tbl_used)
                begin
                    res.got_row    = tbl_row[idx];
                    res.got_column = tbl_column[idx];
                    res.got_value  = tbl_value[idx];
                end
                else
                begin
                    res.status = STATUS_RANGE;
                end
            end
            default: ;
        endcase
        if (!kept)
            res.status = STATUS_FULL;
        res.entries = ENTRY_BITS'(tbl_used);
        return res;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            miss_tally++;
        end
    endtask

    always @(posedge clk)
    begin
        outcome_t want;
        outcome_t fresh;
        if (rst_n)
        begin
            // Retire the result first: it always belongs to an older request.
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unrequested result, expected none, actual status %h count %h",
                             $time, status, entry_count);
                    miss_tally++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("status", want.status, status);
                    check_field("entry_count", want.entries, entry_count);
                    check_field("replaced", want.hit, replaced);
                    check_field("read_row", want.got_row, read_row);
                    check_field("read_column", want.got_column, read_column);
                    check_field("read_value", want.got_value, read_value);
                end
            end
            if (in_valid && !in_stall)
            begin
                fresh           = apply_command(cmd, row, column, value, count, index);
                awaited_results = {awaited_results, fresh};
                if (tbl_used > high_mark)
                    high_mark = tbl_used;
            end
            results_owed  <= awaited_results.size();
            written_depth <= high_mark;
        end
    end

endmodule

### bench/sparse_triplet_upsert_store_core_tb.sv
// Testbench top for the sparse triplet store: stimulus, handshake pacing and verdict.
module sparse_triplet_upsert_store_core_tb;
    import stus_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          HALF_PERIOD  = 2;
    localparam int          RESET_CYCLES = 7;
    localparam int          RANDOM_ITEMS = 1680;
    localparam int          HOLD_AT      = 300;   // request number where the long hold-off starts
    localparam int          PAUSE_AT     = 900;   // request number where the sender drains the block
    localparam int          CALM_ITEMS   = 200;   // final stretch with no idling on either side
    localparam int          LONG_HOLD    = 400;
    localparam int          TAIL_CYCLES  = 300;
    localparam int          CYCLE_LIMIT  = 4000000;
    localparam logic [2:0]  CMD_SPARE_A  = 3'd6;  // unused codes: must change nothing
    localparam logic [2:0]  CMD_SPARE_B  = 3'd7;

    typedef struct {
        logic [2:0]            op;
        logic [PORT_COORD-1:0] r;
        logic [PORT_COORD-1:0] c;
        logic [VALUE_BITS-1:0] v;
        logic [ELEM_BITS-1:0]  n;
        logic [INDEX_BITS-1:0] idx;
    } request_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid;
    logic                  in_stall;
    logic [2:0]            cmd;
    logic [PORT_COORD-1:0] row;
    logic [PORT_COORD-1:0] column;
    logic [VALUE_BITS-1:0] value;
    logic [ELEM_BITS-1:0]  count;
    logic [INDEX_BITS-1:0] index;
    logic                  out_valid;
    logic                  out_stall;
    logic [1:0]            status;
    logic [ENTRY_BITS-1:0] entry_count;
    logic                  replaced;
    logic [PORT_COORD-1:0] read_row;
    logic [PORT_COORD-1:0] read_column;
    logic [VALUE_BITS-1:0] read_value;

    int          mismatches;
    int          results_owed;
    int          written_depth;
    int unsigned cycles = 0;
    bit          hold_ask = 1'b0;
    bit          hold_done = 1'b0;
    bit          calm = 1'b0;
    logic [31:0] seen_xy[$];   // recent {row, column} pairs, reused to provoke upsert hits

    always #(HALF_PERIOD) clk = ~clk;

    sparse_triplet_upsert_store_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .row         (row),
        .column      (column),
        .value       (value),
        .count       (count),
        .index       (index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .entry_count (entry_count),
        .replaced    (replaced),
        .read_row    (read_row),
        .read_column (read_column),
        .read_value  (read_value)
    );

    triplet_store_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .row           (row),
        .column        (column),
        .value         (value),
        .count         (count),
        .index         (index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .entry_count   (entry_count),
        .replaced      (replaced),
        .read_row      (read_row),
        .read_column   (read_column),
        .read_value    (read_value),
        .mismatches    (mismatches),
        .results_owed  (results_owed),
        .written_depth (written_depth)
    );

    // Abort a hung run: the limit sits far above the slowest legal pacing.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic request_t req(logic [2:0] op, logic [PORT_COORD-1:0] r,
                                     logic [PORT_COORD-1:0] c, logic [VALUE_BITS-1:0] v,
                                     logic [ELEM_BITS-1:0] n, logic [INDEX_BITS-1:0] idx);
        request_t rq;
        rq.op  = op;
        rq.r   = r;
        rq.c   = c;
        rq.v   = v;
        rq.n   = n;
        rq.idx = idx;
        return rq;
    endfunction

    // Build one random request. Depth is a lower bound on the number of table
    // slots ever written, so a read never lands on a slot that holds nothing.
    function automatic request_t make_request(int depth);
        request_t    rq;
        int          pick;
        logic [31:0] xy;
        rq.op  = CMD_APPEND;
        rq.r   = PORT_COORD'($urandom);
        rq.c   = PORT_COORD'($urandom);
        rq.v   = {$urandom, $urandom};
        rq.n   = ELEM_BITS'($urandom_range(0, 8));
        rq.idx = '0;

        // Bias coordinates toward earlier ones so upserts find matches,
        // and toward the top of the range so diagonals wrap.
        pick = $urandom_range(0, 9);
        if (pick < 5 && seen_xy.size() != 0)
        begin
            {rq.r, rq.c} = seen_xy[$urandom_range(0, seen_xy.size() - 1)];
        end
        else if (pick == 5)
        begin
            rq.r = ($urandom_range(0, 1) != 0) ? 16'hFFFF - 16'($urandom_range(0, 7)) : '0;
            rq.c = ($urandom_range(0, 1) != 0) ? 16'hFFFF - 16'($urandom_range(0, 7)) : '0;
        end
        if ($urandom_range(0, 9) == 0)
            rq.v = ($urandom_range(0, 1) != 0) ? '1 : '0;

        pick = $urandom_range(0, 99);
        if (pick < 4)
        begin
            rq.op = CMD_CLEAR;
        end
        else if (pick < 19)
        begin
            rq.op = CMD_APPEND;
        end
        else if (pick < 47)
        begin
            rq.op = CMD_UPSERT;
        end
        else if (pick < 57)
        begin
            rq.op = CMD_APPEND_DIAG;
            // Now and then fill most or all of the table in one go.
            if ($urandom_range(0, 49) == 0)
                rq.n = ELEM_BITS'($urandom_range(9, 256));
        end
        else if (pick < 67)
        begin
            rq.op = CMD_UPSERT_DIAG;
            if ($urandom_range(0, 19) == 0)
                rq.n = ELEM_BITS'($urandom_range(9, 24));
        end
        else if (pick < 97)
        begin
            rq.op = CMD_READ;
        end
        else
        begin
            rq.op = ($urandom_range(0, 1) != 0) ? CMD_SPARE_A : CMD_SPARE_B;
        end

        if (rq.op == CMD_READ)
        begin
            if (depth == 0)
                rq.op = CMD_APPEND;
            else
                rq.idx = INDEX_BITS'($urandom_range(0, depth - 1));
        end
        if (rq.op != CMD_READ && rq.op != CMD_CLEAR)
        begin
            xy      = {rq.r, rq.c};
            seen_xy = {seen_xy, xy};
            if (seen_xy.size() > 48)
                void'(seen_xy.pop_front());
        end
        return rq;
    endfunction

    // Present one request and hold it until the block takes it.
    task automatic offer(request_t rq);
        in_valid <= 1'b1;
        cmd      <= rq.op;
        row      <= rq.r;
        column   <= rq.c;
        value    <= rq.v;
        count    <= rq.n;
        index    <= rq.idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid for a short random burst now and then, then offer.
    task automatic send(request_t rq);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        offer(rq);
    endtask

    // Advance until every owed result has come back; the owed count is registered.
    task automatic wait_drained();
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
    endtask

    // Result side: short random stalls, one long hold-off on request, none at the end.
    initial
    begin
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_ask && !hold_done)
            begin
                // Hold long enough that the output register and the core both fill
                // and the input side has to stall.
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Request side.
    initial
    begin
        in_valid <= 1'b0;
        cmd      <= CMD_CLEAR;
        row      <= '0;
        column   <= '0;
        value    <= '0;
        count    <= '0;
        index    <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes and a read of each, then a replaced entry and a new one.
        send(req(CMD_APPEND, 16'h0000, 16'h0000, 64'h0, 9'd0, 8'd0));
        send(req(CMD_APPEND, 16'hFFFF, 16'hFFFF, '1, 9'd511, 8'hFF));
        send(req(CMD_READ, 16'h0000, 16'h0000, 64'h0, 9'd0, 8'd0));
        send(req(CMD_READ, 16'hFFFF, 16'hFFFF, '1, 9'd0, 8'd1));
        send(req(CMD_UPSERT, 16'hFFFF, 16'hFFFF, 64'h0123_4567_89AB_CDEF, 9'd0, 8'd0));
        send(req(CMD_UPSERT, 16'h1234, 16'h5678, 64'hDEAD_BEEF_0000_0001, 9'd0, 8'd0));
        // Store a duplicate, then check that an upsert only touches the first copy.
        send(req(CMD_APPEND, 16'h0000, 16'h0000, 64'h5555_5555_5555_5555, 9'd0, 8'd0));
        send(req(CMD_UPSERT, 16'h0000, 16'h0000, 64'hAAAA_AAAA_AAAA_AAAA, 9'd0, 8'd0));
        send(req(CMD_READ, 16'h0000, 16'h0000, 64'h0, 9'd0, 8'd3));
        send(req(CMD_READ, 16'h0000, 16'h0000, 64'h0, 9'd0, 8'd0));
        // Unused codes leave the table alone.
        send(req(CMD_SPARE_A, 16'h0F0F, 16'hF0F0, 64'h1, 9'd5, 8'd2));
        send(req(CMD_SPARE_B, 16'hFFFF, 16'hFFFF, '1, 9'd256, 8'hFF));
        // Empty diagonals, then diagonals whose coordinates wrap past the top.
        send(req(CMD_APPEND_DIAG, 16'h0042, 16'h0043, 64'h7, 9'd0, 8'd0));
        send(req(CMD_UPSERT_DIAG, 16'h0042, 16'h0043, 64'h7, 9'd0, 8'd0));
        send(req(CMD_APPEND_DIAG, 16'hFFF0, 16'hFFF8, 64'h1111, 9'd20, 8'd0));
        send(req(CMD_UPSERT_DIAG, 16'hFFF0, 16'hFFF8, 64'h2222, 9'd24, 8'd0));
        send(req(CMD_READ, 16'h0000, 16'h0000, 64'h0, 9'd0, 8'd27));
        // After a clear, old slots fall out of range.
        send(req(CMD_CLEAR, 16'h0000, 16'h0000, 64'h0, 9'd0, 8'd0));
        send(req(CMD_READ, 16'h0000, 16'h0000, 64'h0, 9'd0, 8'd5));
        // Fill the table, then hit it with an append, a matching and a missing upsert.
        send(req(CMD_APPEND_DIAG, 16'h0100, 16'h0200, 64'h3333, 9'd256, 8'd0));
        send(req(CMD_APPEND, 16'h0001, 16'h0002, 64'h4444, 9'd0, 8'd0));
        send(req(CMD_UPSERT, 16'h0100, 16'h0200, 64'h5555, 9'd0, 8'd0));
        send(req(CMD_UPSERT_DIAG, 16'h8000, 16'h8001, 64'h6666, 9'd2, 8'd0));
        send(req(CMD_READ, 16'h0000, 16'h0000, 64'h0, 9'd0, 8'd255));
        send(req(CMD_CLEAR, 16'h0000, 16'h0000, 64'h0, 9'd0, 8'd0));
        // Longest diagonal upsert, every element a miss, ending with a full table.
        send(req(CMD_UPSERT_DIAG, 16'h0000, 16'h0000, 64'h7777, 9'd256, 8'd0));

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == HOLD_AT)
                hold_ask = 1'b1;
            if (k == PAUSE_AT)
            begin
                in_valid <= 1'b0;
                wait_drained();
            end
            if (k == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            send(make_request(written_depth));
        end

        // Drop valid, drain, then leave room for any stray result to show up.
        in_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
